// File: design/mkdr_pkg.sv
// Package for the matrix keypad debounce and auto-repeat block.
// Holds the mode type, the result struct, keypad geometry and the key table.
// No dependencies.
package mkdr_pkg;

    // Keypad geometry (4 rows, 3 columns)
    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 3;

    localparam logic [7:0] NO_KEY_CODE = 8'hFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_HOLD     = 2'd1;
    localparam logic [1:0] CFG_REPEAT   = 2'd2;

    typedef enum logic [2:0] {
        MODE_UP       = 3'd0,
        MODE_DEBOUNCE = 3'd1,
        MODE_PRESSED  = 3'd2,
        MODE_DOWN     = 3'd3,
        MODE_HELD     = 3'd4,
        MODE_RELEASED = 3'd5
    } mode_t;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] key_code;
        logic [2:0] keypad_mode;
    } result_t;

    // ASCII code of the key at a zero-based row and column
    function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] code;
        begin
            code = NO_KEY_CODE;
            case ({row, col})
                4'b00_00: code = "1";
                4'b00_01: code = "2";
                4'b00_10: code = "3";
                4'b01_00: code = "4";
                4'b01_01: code = "5";
                4'b01_10: code = "6";
                4'b10_00: code = "7";
                4'b10_01: code = "8";
                4'b10_10: code = "9";
                4'b11_00: code = "*";
                4'b11_01: code = "0";
                4'b11_10: code = "#";
                default:  code = NO_KEY_CODE;
            endcase
            return code;
        end
    endfunction

endpackage

// File: design/matrix_keypad_debounce_repeat.sv
// Top level of the matrix keypad scanner with debounce and auto-repeat.
// Depends on mkdr_pkg (mode type, result struct, key table).
//
// One poll is taken per request on the input channel and gives exactly one
// result: key_valid/key_code when a key report is issued, and the mode after
// the poll. Key decode, 32-bit wrapping elapsed time and the mode update are
// combinational between the mode/key/stamp registers and the result register,
// so a new poll is accepted every cycle while results are
// taken. A two-entry output stage (result register plus skid register) keeps
// the input ready for one more poll while a result waits; input ready drops
// only while both hold results. Timing registers are written through the
// configuration channel, which is always ready; writes to an index past the
// last register are ignored.
module matrix_keypad_debounce_repeat
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Poll request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cols_all_rows,
    input  logic [2:0]  cols_row_one,
    input  logic [2:0]  cols_row_two,
    input  logic [2:0]  cols_row_three,
    input  logic [2:0]  cols_row_four,
    input  logic [31:0] now_ms,

    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        key_valid,
    output logic [7:0]  key_code,
    output logic [2:0]  keypad_mode
);
    import mkdr_pkg::*;

    logic [15:0] debounce_ms_reg;
    logic [15:0] hold_ms_reg;
    logic [15:0] repeat_ms_reg;

    mode_t       mode_reg, mode_next;
    logic [7:0]  sensed_key_reg, sensed_key_next;
    logic [31:0] stamp_ms_reg, stamp_ms_next;

    result_t     out_reg, skid_reg, result_next;
    logic        out_valid_reg, skid_valid_reg;

    logic        in_fire;
    logic [2:0]  row_cols [4];
    logic [1:0]  col_idx;
    logic [1:0]  row_idx;
    logic        col_found;
    logic        row_found;
    logic [7:0]  pressed;
    logic [31:0] elapsed;
    logic [7:0]  report;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;

    // Write timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= 16'd20;
            hold_ms_reg     <= 16'd500;
            repeat_ms_reg   <= 16'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_ms_reg <= cfg_data;
                CFG_HOLD:     hold_ms_reg     <= cfg_data;
                CFG_REPEAT:   repeat_ms_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Decode the sensed key: lowest column wins, then first active row
    assign row_cols[0] = cols_row_one;
    assign row_cols[1] = cols_row_two;
    assign row_cols[2] = cols_row_three;
    assign row_cols[3] = cols_row_four;

    always_comb
    begin
        col_found = 1'b1;
        if (cols_all_rows[0])
            col_idx = 2'd0;
        else if (cols_all_rows[1])
            col_idx = 2'd1;
        else if (cols_all_rows[2])
            col_idx = 2'd2;
        else
        begin
            col_idx   = 2'd0;
            col_found = 1'b0;
        end

        row_idx   = 2'd0;
        row_found = 1'b0;
        for (int r = NUM_ROWS - 1; r >= 0; r--)
        begin
            if (row_cols[r] != 3'd0)
            begin
                row_idx   = 2'(r);
                row_found = 1'b1;
            end
        end

        if (col_found && row_found && ({30'd0, col_idx} < 32'(NUM_COLS)))
            pressed = key_lookup(row_idx, col_idx);
        else
            pressed = NO_KEY_CODE;
    end

    assign elapsed = now_ms - stamp_ms_reg;

    // Next mode, sensed key, stamp and report
    always_comb
    begin
        mode_next       = mode_reg;
        sensed_key_next = sensed_key_reg;
        stamp_ms_next   = stamp_ms_reg;
        report          = NO_KEY_CODE;

        case (mode_reg)
            MODE_UP:
            begin
                sensed_key_next = pressed;
                if (pressed != NO_KEY_CODE)
                begin
                    stamp_ms_next = now_ms;
                    mode_next     = MODE_DEBOUNCE;
                end
            end
            MODE_DEBOUNCE:
            begin
                if (pressed != NO_KEY_CODE)
                begin
                    if (pressed == sensed_key_reg)
                    begin
                        if (elapsed > {16'd0, debounce_ms_reg})
                        begin
                            mode_next     = MODE_PRESSED;
                            stamp_ms_next = now_ms;
                            report        = sensed_key_reg;
                        end
                    end
                    else
                    begin
                        stamp_ms_next   = now_ms;
                        sensed_key_next = pressed;
                    end
                end
                else
                begin
                    mode_next       = MODE_UP;
                    sensed_key_next = NO_KEY_CODE;
                end
            end
            MODE_PRESSED:
            begin
                if (pressed != NO_KEY_CODE)
                    mode_next = (sensed_key_reg == pressed) ? MODE_DOWN : MODE_DEBOUNCE;
                else
                    mode_next = MODE_RELEASED;
                stamp_ms_next = now_ms;
            end
            MODE_DOWN:
            begin
                if (sensed_key_reg == pressed)
                begin
                    if (elapsed > {16'd0, hold_ms_reg})
                    begin
                        mode_next     = MODE_HELD;
                        stamp_ms_next = now_ms;
                    end
                end
                else
                begin
                    mode_next     = MODE_RELEASED;
                    stamp_ms_next = now_ms;
                end
            end
            MODE_HELD:
            begin
                if (sensed_key_reg != pressed)
                begin
                    mode_next     = MODE_RELEASED;
                    stamp_ms_next = now_ms;
                    report        = sensed_key_reg;
                end
                else if (elapsed > {16'd0, repeat_ms_reg})
                begin
                    stamp_ms_next = now_ms;
                    report        = sensed_key_reg;
                end
            end
            MODE_RELEASED:
            begin
                if (pressed == NO_KEY_CODE)
                    mode_next = MODE_UP;
                else
                begin
                    mode_next       = MODE_DEBOUNCE;
                    sensed_key_next = pressed;
                    stamp_ms_next   = now_ms;
                end
            end
            default:
            begin
                // Recover from an unused mode code
                mode_next       = MODE_UP;
                sensed_key_next = 8'd0;
                stamp_ms_next   = 32'd0;
            end
        endcase

        result_next.key_valid   = (report != NO_KEY_CODE);
        result_next.key_code    = (report != NO_KEY_CODE) ? report : 8'd0;
        result_next.keypad_mode = mode_next;
    end

    // Advance keypad state on each accepted poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_UP;
            sensed_key_reg <= NO_KEY_CODE;
            stamp_ms_reg   <= 32'd0;
        end
        else if (in_fire)
        begin
            mode_reg       <= mode_next;
            sensed_key_reg <= sensed_key_next;
            stamp_ms_reg   <= stamp_ms_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= in_fire;
            end
            else if (in_fire)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_fire)
                out_reg <= result_next;
        end
        else if (in_fire)
            skid_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign key_valid   = out_reg.key_valid;
    assign key_code    = out_reg.key_code;
    assign keypad_mode = out_reg.keypad_mode;

    // Skid stage only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    // A report carries a real key code, no report carries zero
    a_report_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (key_valid ? (key_code != 8'd0 && key_code != NO_KEY_CODE)
                                     : (key_code == 8'd0)))
        else $error("key code does not match report flag");

    // Held mode always tracks a decoded key
    a_held_has_key: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_HELD) |-> (sensed_key_reg != NO_KEY_CODE))
        else $error("held mode without a sensed key");

    // A stalled result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");

endmodule
